// ===== rtl/core/dcp_pkg.sv =====
package dcp_pkg;

    localparam logic [15:0] K_ONE     = 16'd32768;
    localparam int          DIV_QBITS = 34;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PROJ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FIXED      = 2'd1,
        ST_COINCIDENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MUL_SQ = 2'd0,
        MUL_WK = 2'd1,
        MUL_EW = 2'd2,
        MUL_DS = 2'd3
    } mul_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_WRITE,
        S_RDA,
        S_LDA,
        S_LDB,
        S_DIFF,
        S_SQ,
        S_ACC,
        S_SQRT,
        S_ERR,
        S_CHK,
        S_WK,
        S_EW,
        S_DIVS,
        S_DIVSW,
        S_MD,
        S_DD,
        S_DDW,
        S_WRA,
        S_WRB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     rd_en;
        logic     rd_sel_b;
        logic     load_a;
        logic     load_b;
        logic     wr_en;
        logic     wr_sel_b;
        logic     diff;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     sqrt_step;
        logic [4:0] sq_idx;
        logic     err_en;
        logic     set_status;
        status_t  status_val;
        logic     smag_en;
        logic     div_start;
        logic     div_sel_len;
        logic     upd_en;
        logic     part;
        logic [1:0] axis;
        logic     res_load;
    } dcp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    both_fixed;
        logic    coincident;
        logic    div_done;
    } dcp_stat_t;

endpackage

// ===== rtl/core/dcp_div.sv =====
module dcp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [33:0] quot
);
    import dcp_pkg::*;

    localparam logic [5:0] LAST = 6'(DIV_QBITS - 1);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [33:0] dq_reg;
    logic [32:0] dvs_reg;
    logic [33:0] trial;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, dq_reg[33]};
        ge    = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient is known to fit in the low bits, so the high part starts as remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {3'b0, dividend[63:34]};
            dq_reg  <= dividend[33:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 33'(trial - {1'b0, dvs_reg}) : trial[32:0];
            dq_reg  <= {dq_reg[32:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

// ===== rtl/core/dcp_datapath.sv =====
module dcp_datapath #(
    parameter int PARTICLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dcp_pkg::dcp_cmd_t  cmd,
    output dcp_pkg::dcp_stat_t stat,
    input  logic [1:0]         opcode,
    input  logic [9:0]         index_a,
    input  logic [9:0]         index_b,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        inv_mass,
    input  logic [30:0]        rest_length,
    input  logic [15:0]        stiffness,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [15:0]        out_inv_mass,
    output logic signed [31:0] constraint_error,
    output logic [1:0]         status
);
    import dcp_pkg::*;

    localparam int          IW = $clog2(PARTICLES);
    localparam logic [31:0] PW = 32'(PARTICLES);

    function automatic logic [IW-1:0] wrap_idx(input logic [9:0] v);
        logic [31:0] t;
        t = 32'(v);
        for (int s = 9; s >= 0; s--)
        begin
            if (t >= (PW << s))
                t = t - (PW << s);
        end
        return t[IW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic [95:0] pos_mem  [PARTICLES];
    logic [15:0] mass_mem [PARTICLES];

    opcode_t            op_reg;
    logic [IW-1:0]      ia_reg, ib_reg;
    logic [30:0]        rest_reg;
    logic [15:0]        k_reg;
    logic signed [31:0] pa_reg [3];
    logic signed [31:0] pb_reg [3];
    logic [15:0]        wa_reg, wb_reg;
    logic signed [32:0] d_reg [3];
    logic [63:0]        acc_reg, root_reg, prod_reg;
    logic [32:0]        len_reg;
    logic signed [31:0] err_reg;
    status_t            status_reg;
    logic [31:0]        smag_reg [2];
    logic [95:0]        rd_pos_reg;
    logic [15:0]        rd_mass_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg, res_err_reg;
    logic [15:0]        res_mass_reg;
    logic [1:0]         res_status_reg;

    logic [32:0]        mag [3];
    logic [30:0]        m [3];
    logic               shift_w;
    logic [31:0]        err_mag;
    logic signed [32:0] err_ext;
    logic [15:0]        w_sel;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        prod_full;
    logic [63:0]        bit_w, trial_w;
    logic [32:0]        len_w;
    logic signed [34:0] diff_w;
    logic [63:0]        div_dividend;
    logic [32:0]        div_divisor;
    logic               div_done;
    logic [33:0]        quot;
    logic signed [35:0] delta_w;
    logic               neg_w;
    logic [IW-1:0]      rd_addr, wr_addr;

    dcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (quot)
    );

    always_comb
    begin
        shift_w = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            mag[j]  = d_reg[j][32] ? 33'(-d_reg[j]) : 33'(d_reg[j]);
            shift_w = shift_w | mag[j][32] | mag[j][31];
        end
        for (int j = 0; j < 3; j++)
            m[j] = shift_w ? mag[j][31:1] : mag[j][30:0];

        err_ext = 33'(err_reg);
        err_mag = err_reg[31] ? 32'(-err_ext) : 32'(err_ext);
        w_sel   = cmd.part ? wb_reg : wa_reg;

        case (cmd.mul_sel)
            MUL_SQ:
            begin
                mul_a = 33'(m[cmd.axis]);
                mul_b = 32'(m[cmd.axis]);
            end
            MUL_WK:
            begin
                mul_a = 33'(w_sel);
                mul_b = 32'(k_reg);
            end
            MUL_EW:
            begin
                mul_a = 33'(err_mag);
                mul_b = prod_reg[31:0];
            end
            default:
            begin
                mul_a = mag[cmd.axis];
                mul_b = smag_reg[cmd.part];
            end
        endcase
        prod_full = 65'(mul_a) * 65'(mul_b);

        bit_w   = 64'd1 << {cmd.sq_idx, 1'b0};
        trial_w = root_reg + bit_w;

        len_w  = shift_w ? {root_reg[31:0], 1'b0} : {1'b0, root_reg[31:0]};
        diff_w = $signed({2'b0, len_w}) - $signed({4'b0, rest_reg});

        // mass share divides by the mass sum after dropping the q1.15 scale
        div_dividend = cmd.div_sel_len ? prod_reg : (prod_reg >> 15);
        div_divisor  = cmd.div_sel_len ? len_reg : 33'({1'b0, wa_reg} + {1'b0, wb_reg});

        neg_w   = d_reg[cmd.axis][32] ^ err_reg[31];
        delta_w = neg_w ? -$signed({2'b0, quot}) : $signed({2'b0, quot});

        rd_addr = cmd.rd_sel_b ? ib_reg : ia_reg;
        wr_addr = cmd.wr_sel_b ? ib_reg : ia_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            if (cmd.wr_sel_b)
            begin
                pos_mem[wr_addr]  <= {pb_reg[2], pb_reg[1], pb_reg[0]};
                mass_mem[wr_addr] <= wb_reg;
            end
            else
            begin
                pos_mem[wr_addr]  <= {pa_reg[2], pa_reg[1], pa_reg[0]};
                mass_mem[wr_addr] <= wa_reg;
            end
        end
        if (cmd.rd_en)
        begin
            rd_pos_reg  <= pos_mem[rd_addr];
            rd_mass_reg <= mass_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode_t'(opcode);
            ia_reg     <= wrap_idx(index_a);
            ib_reg     <= wrap_idx(index_b);
            rest_reg   <= rest_length;
            k_reg      <= (stiffness > K_ONE) ? K_ONE : stiffness;
            err_reg    <= '0;
            status_reg <= ST_DONE;
            if (opcode_t'(opcode) == OP_NOP)
            begin
                pa_reg[0] <= '0;
                pa_reg[1] <= '0;
                pa_reg[2] <= '0;
                wa_reg    <= '0;
            end
            else
            begin
                pa_reg[0] <= pos_x;
                pa_reg[1] <= pos_y;
                pa_reg[2] <= pos_z;
                wa_reg    <= inv_mass;
            end
        end
        if (cmd.load_a)
        begin
            pa_reg[0] <= rd_pos_reg[31:0];
            pa_reg[1] <= rd_pos_reg[63:32];
            pa_reg[2] <= rd_pos_reg[95:64];
            wa_reg    <= rd_mass_reg;
        end
        if (cmd.load_b)
        begin
            pb_reg[0] <= rd_pos_reg[31:0];
            pb_reg[1] <= rd_pos_reg[63:32];
            pb_reg[2] <= rd_pos_reg[95:64];
            wb_reg    <= rd_mass_reg;
        end
        if (cmd.diff)
        begin
            for (int j = 0; j < 3; j++)
                d_reg[j] <= 33'(pa_reg[j]) - 33'(pb_reg[j]);
            acc_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.mul_en)
            prod_reg <= prod_full[63:0];
        if (cmd.acc_en)
            acc_reg <= acc_reg + prod_reg;
        // one result bit of the integer root per step
        if (cmd.sqrt_step)
        begin
            if (acc_reg >= trial_w)
            begin
                acc_reg  <= acc_reg - trial_w;
                root_reg <= (root_reg >> 1) + bit_w;
            end
            else
                root_reg <= root_reg >> 1;
        end
        if (cmd.err_en)
        begin
            len_reg <= len_w;
            err_reg <= sat32(36'(diff_w));
        end
        if (cmd.set_status)
            status_reg <= cmd.status_val;
        if (cmd.smag_en)
            smag_reg[cmd.part] <= quot[31:0];
        if (cmd.upd_en)
        begin
            if (cmd.part)
                pb_reg[cmd.axis] <= sat32(36'(pb_reg[cmd.axis]) + delta_w);
            else
                pa_reg[cmd.axis] <= sat32(36'(pa_reg[cmd.axis]) - delta_w);
        end
        if (cmd.res_load)
        begin
            res_x_reg      <= pa_reg[0];
            res_y_reg      <= pa_reg[1];
            res_z_reg      <= pa_reg[2];
            res_mass_reg   <= wa_reg;
            res_err_reg    <= err_reg;
            res_status_reg <= status_reg;
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.both_fixed = (wa_reg == '0) && (wb_reg == '0);
        stat.coincident = (len_reg == '0);
        stat.div_done   = div_done;
    end

    assign out_x            = res_x_reg;
    assign out_y            = res_y_reg;
    assign out_z            = res_z_reg;
    assign out_inv_mass     = res_mass_reg;
    assign constraint_error = res_err_reg;
    assign status           = res_status_reg;

endmodule

// ===== rtl/core/dcp_ctrl.sv =====
module dcp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dcp_pkg::dcp_stat_t stat,
    output dcp_pkg::dcp_cmd_t  cmd
);
    import dcp_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       part_reg, part_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            part_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            part_reg      <= part_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        part_next  = part_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_sel    = MUL_SQ;
        cmd.status_val = ST_DONE;
        cmd.sq_idx     = step_reg;
        cmd.axis       = step_reg[1:0];
        cmd.part       = part_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    OP_WRITE: state_next = S_WRITE;
                    OP_READ:  state_next = S_RDA;
                    OP_PROJ:  state_next = S_RDA;
                    default:  state_next = S_DONE;
                endcase
            end
            S_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_DONE;
            end
            S_RDA:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LDA;
            end
            S_LDA:
            begin
                cmd.load_a = 1'b1;
                if (stat.op == OP_PROJ)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel_b = 1'b1;
                    state_next   = S_LDB;
                end
                else
                    state_next = S_DONE;
            end
            S_LDB:
            begin
                cmd.load_b = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                step_next  = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (step_reg == 5'd2)
                begin
                    step_next  = 5'd31;
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = S_SQ;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == '0)
                    state_next = S_ERR;
                else
                    step_next = step_reg - 5'd1;
            end
            S_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.both_fixed)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_FIXED;
                    state_next     = S_DONE;
                end
                else if (stat.coincident)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_COINCIDENT;
                    state_next     = S_DONE;
                end
                else
                begin
                    part_next  = 1'b0;
                    state_next = S_WK;
                end
            end
            S_WK:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WK;
                state_next  = S_EW;
            end
            S_EW:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_EW;
                state_next  = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVSW;
            end
            S_DIVSW:
            begin
                if (stat.div_done)
                begin
                    cmd.smag_en = 1'b1;
                    if (part_reg)
                    begin
                        part_next  = 1'b0;
                        step_next  = '0;
                        state_next = S_MD;
                    end
                    else
                    begin
                        part_next  = 1'b1;
                        state_next = S_WK;
                    end
                end
            end
            S_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DS;
                state_next  = S_DD;
            end
            S_DD:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_len = 1'b1;
                state_next      = S_DDW;
            end
            S_DDW:
            begin
                cmd.div_sel_len = 1'b1;
                if (stat.div_done)
                begin
                    cmd.upd_en = 1'b1;
                    if (step_reg == 5'd2)
                    begin
                        step_next = '0;
                        if (part_reg)
                            state_next = S_WRA;
                        else
                        begin
                            part_next  = 1'b1;
                            state_next = S_MD;
                        end
                    end
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        state_next = S_MD;
                    end
                end
            end
            S_WRA:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel_b = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // wait only while the previous word is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/distance_constraint_projector.sv =====
// channel   direction   handshake              payload
// in        to block    in_valid / in_ready    opcode index_a index_b pos_x pos_y pos_z
//                                              inv_mass rest_length stiffness
// out       from block  out_valid / out_ready  out_x out_y out_z out_inv_mass
//                                              constraint_error status
//
// one item at a time; a projection takes the longest of the operations
// (two 34-step serial divides for the mass shares, six for the axis corrections,
// a 32-step root and a shared multiplier set its length)
// reset clears the controller and the divider state only; particle table contents are undefined until written
// a new word is taken while the last result waits in the output register
module distance_constraint_projector #(
    parameter int PARTICLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [9:0]         index_a,
    input  logic [9:0]         index_b,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        inv_mass,
    input  logic [30:0]        rest_length,
    input  logic [15:0]        stiffness,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [15:0]        out_inv_mass,
    output logic signed [31:0] constraint_error,
    output logic [1:0]         status
);
    import dcp_pkg::*;

    dcp_cmd_t  cmd;
    dcp_stat_t stat;

    dcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dcp_datapath #(
        .PARTICLES (PARTICLES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (opcode),
        .index_a          (index_a),
        .index_b          (index_b),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .inv_mass         (inv_mass),
        .rest_length      (rest_length),
        .stiffness        (stiffness),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_z            (out_z),
        .out_inv_mass     (out_inv_mass),
        .constraint_error (constraint_error),
        .status           (status)
    );

endmodule

// ===== test/tb_distance_constraint_projector.sv =====
module tb_distance_constraint_projector;
    import dcp_pkg::*;

    localparam int N_RANDOM   = 930;
    localparam int STALL_LIM  = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 400;

    typedef struct {
        opcode_t            op;
        logic [9:0]         a;
        logic [9:0]         b;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        m;
        logic [30:0]        rest;
        logic [15:0]        k;
        bit                 typed;
        logic [31:0]        ex;
        logic [31:0]        ey;
        logic [31:0]        ez;
        logic [15:0]        em;
        logic [31:0]        ee;
        status_t            es;
    } word_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] m;
        logic [31:0] err;
        status_t     st;
    } particle_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = '0;
    logic [9:0]         index_a = '0;
    logic [9:0]         index_b = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [15:0]        inv_mass = '0;
    logic [30:0]        rest_length = '0;
    logic [15:0]        stiffness = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        out_inv_mass;
    logic signed [31:0] constraint_error;
    logic [1:0]         status;

    distance_constraint_projector i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .index_a          (index_a),
        .index_b          (index_b),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .inv_mass         (inv_mass),
        .rest_length      (rest_length),
        .stiffness        (stiffness),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_z            (out_z),
        .out_inv_mass     (out_inv_mass),
        .constraint_error (constraint_error),
        .status           (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the particle table
    longint        shadow_pos [1024][3];
    logic [15:0]   shadow_mass [1024];
    bit            shadow_written [1024];
    int unsigned   written_list [$];
    particle_res_t pending_res [$];

    int  mismatches = 0;
    bit  timed_out = 1'b0;
    bit  hold_req = 1'b0;
    bit  sender_done = 1'b0;
    int  idle_cycles = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // applies one word to the shadow table and returns the expected result
    function automatic particle_res_t apply_word(word_t w);
        particle_res_t   res;
        int unsigned     a = 32'(w.a);
        int unsigned     b = 32'(w.b);
        longint          d [3];
        longint unsigned mag [3];
        longint unsigned sum = 0;
        longint unsigned len;
        longint          err = 0;
        longint          wa;
        longint          wb;
        longint          kk;
        longint          den;
        longint          sa;
        longint          sb;
        longint          da;
        longint          db;
        int              sh = 0;
        status_t         st = ST_DONE;

        res = '{'0, '0, '0, '0, '0, ST_DONE};
        if (w.op == OP_NOP)
            return res;
        if (w.op == OP_WRITE)
        begin
            shadow_pos[a][0] = longint'(w.x);
            shadow_pos[a][1] = longint'(w.y);
            shadow_pos[a][2] = longint'(w.z);
            shadow_mass[a] = w.m;
            if (!shadow_written[a])
                written_list.push_back(a);
            shadow_written[a] = 1'b1;
        end
        else if (w.op == OP_PROJ)
        begin
            wa = longint'(shadow_mass[a]);
            wb = longint'(shadow_mass[b]);
            kk = (w.k > K_ONE) ? longint'(K_ONE) : longint'(w.k);
            for (int j = 0; j < 3; j++)
            begin
                d[j] = shadow_pos[a][j] - shadow_pos[b][j];
                mag[j] = (d[j] < 0) ? longint'(-d[j]) : longint'(d[j]);
                if (mag[j] >= (64'd1 << 31))
                    sh = 1;
            end
            for (int j = 0; j < 3; j++)
                sum += (mag[j] >> sh) * (mag[j] >> sh);
            len = int_sqrt(sum) << sh;
            err = sat32(longint'(len) - longint'(w.rest));
            if (wa + wb == 0)
                st = ST_FIXED;
            else if (len == 0)
                st = ST_COINCIDENT;
            else
            begin
                den = (wa + wb) * 32768;
                sa = (err * wa * kk) / den;
                sb = (err * wb * kk) / den;
                for (int j = 0; j < 3; j++)
                begin
                    da = (d[j] * sa) / longint'(len);
                    db = (d[j] * sb) / longint'(len);
                    shadow_pos[a][j] = sat32(shadow_pos[a][j] - da);
                    shadow_pos[b][j] = sat32(shadow_pos[b][j] + db);
                end
            end
        end
        res.x = shadow_pos[a][0][31:0];
        res.y = shadow_pos[a][1][31:0];
        res.z = shadow_pos[a][2][31:0];
        res.m = shadow_mass[a];
        res.err = err[31:0];
        res.st = st;
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_word(word_t w);
        particle_res_t res;
        in_valid    = 1'b1;
        opcode      = w.op;
        index_a     = w.a;
        index_b     = w.b;
        pos_x       = w.x;
        pos_y       = w.y;
        pos_z       = w.z;
        inv_mass    = w.m;
        rest_length = w.rest;
        stiffness   = w.k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = apply_word(w);
        if (w.typed)
            res = '{w.ex, w.ey, w.ez, w.em, w.ee, w.es};
        pending_res.push_back(res);
        @(negedge clk);
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int    sel = $urandom_range(0, 99);
        w.typed = 1'b0;
        w.a = 10'($urandom_range(0, 1023));
        w.b = 10'($urandom_range(0, 1023));
        w.x = $urandom();
        w.y = $urandom();
        w.z = $urandom();
        w.m = 16'($urandom());
        w.rest = ($urandom_range(0, 4) == 0) ? 31'($urandom())
            : 31'($urandom_range(0, 32'h003f_ffff));
        w.k = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
        if (written_list.size() < 2 || sel < 30)
        begin
            w.op = OP_WRITE;
            // keep to a small working set so projections find written pairs
            if ($urandom_range(0, 3) != 0)
                w.a = 10'($urandom_range(0, 31) * 33);
            w.x = rand_coord();
            w.y = rand_coord();
            w.z = rand_coord();
            if ($urandom_range(0, 6) == 0)
                w.m = '0;
            else if ($urandom_range(0, 1) == 0)
                w.m = 16'($urandom_range(1, 1024));
        end
        else if (sel < 50)
        begin
            w.op = OP_READ;
            w.a = 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
        end
        else if (sel < 96)
        begin
            w.op = OP_PROJ;
            w.a = 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
            w.b = ($urandom_range(0, 9) == 0) ? w.a
                : 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
        end
        else
            w.op = OP_NOP;
        return w;
    endfunction

    word_t dir_tab [$];

    initial
    begin
        word_t w;
        // write echoes, reads, skips and extremes
        dir_tab.push_back('{OP_WRITE, 10'd0, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd256, 31'd0,
            16'd0, 1'b1, 32'd0, 32'd0, 32'd0, 16'd256, 32'd0, ST_DONE});
        dir_tab.push_back('{OP_WRITE, 10'd1023, 10'd0, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 16'hffff, 31'd0, 16'd0, 1'b1, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 16'hffff, 32'd0, ST_DONE});
        dir_tab.push_back('{OP_WRITE, 10'd1, 10'd0, 32'h80000000, 32'h80000000, 32'h80000000,
            16'd0, 31'd0, 16'd0, 1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 16'd0,
            32'd0, ST_DONE});
        dir_tab.push_back('{OP_WRITE, 10'd2, 10'd0, 32'h00030000, 32'h00040000, 32'sd0,
            16'd256, 31'd0, 16'd0, 1'b1, 32'h00030000, 32'h00040000, 32'd0, 16'd256, 32'd0,
            ST_DONE});
        dir_tab.push_back('{OP_WRITE, 10'd3, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd0, 1'b1, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0, ST_DONE});
        dir_tab.push_back('{OP_READ, 10'd1023, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd0, 1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff, 32'd0, ST_DONE});
        dir_tab.push_back('{OP_READ, 10'd1, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd0, 1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 16'd0, 32'd0, ST_DONE});
        // both fixed and far apart
        dir_tab.push_back('{OP_PROJ, 10'd1, 10'd3, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd32768, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        // same particle on both ends
        dir_tab.push_back('{OP_PROJ, 10'd0, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0,
            31'h00050000, 16'd32768, 1'b1, 32'd0, 32'd0, 32'd0, 16'd256, 32'hfffb0000,
            ST_COINCIDENT});
        dir_tab.push_back('{OP_PROJ, 10'd0, 10'd3, 32'sd0, 32'sd0, 32'sd0, 16'd0,
            31'h7fffffff, 16'hffff, 1'b1, 32'd0, 32'd0, 32'd0, 16'd256, 32'h80000001,
            ST_COINCIDENT});
        dir_tab.push_back('{OP_PROJ, 10'd2, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd32768, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        dir_tab.push_back('{OP_PROJ, 10'd2, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0,
            31'h00020000, 16'hffff, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        dir_tab.push_back('{OP_PROJ, 10'd0, 10'd2, 32'sd0, 32'sd0, 32'sd0, 16'd0,
            31'h00010000, 16'd0, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        dir_tab.push_back('{OP_PROJ, 10'd1023, 10'd1, 32'sd0, 32'sd0, 32'sd0, 16'd0,
            31'h7fffffff, 16'd16384, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        dir_tab.push_back('{OP_NOP, 10'd1023, 10'd1023, 32'hffffffff, 32'hffffffff,
            32'hffffffff, 16'hffff, 31'h7fffffff, 16'hffff, 1'b1, 32'd0, 32'd0, 32'd0, 16'd0,
            32'd0, ST_DONE});
        dir_tab.push_back('{OP_PROJ, 10'd2, 10'd1023, 32'sd0, 32'sd0, 32'sd0, 16'd0,
            31'h00100000, 16'd32767, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        dir_tab.push_back('{OP_READ, 10'd2, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd0, 1'b0, '0, '0, '0, '0, '0, ST_DONE});
        dir_tab.push_back('{OP_READ, 10'd1023, 10'd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0,
            16'd0, 1'b0, '0, '0, '0, '0, '0, ST_DONE});

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            send_word(dir_tab[i]);
            idle_sender(pick_gap());
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_req = 1'b1;
            if (n == 600)
            begin
                in_valid = 1'b0;
                wait (pending_res.size() == 0);
                @(negedge clk);
            end
            w = random_word();
            send_word(w);
            // stretches with back-to-back words
            if ((n / 100) % 3 != 1)
                idle_sender(pick_gap());
        end
        in_valid = 1'b0;
        sender_done = 1'b1;
    end

    // result side ready, with one long hold to fill the block
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = ($urandom_range(0, 3) != 0);
            if (!out_ready && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 60)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        particle_res_t e;
        if (out_valid && out_ready)
        begin
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word x=%h", out_x);
            end
            else
            begin
                e = pending_res.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z
                    || out_inv_mass !== e.m || constraint_error !== e.err
                    || status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h %h %0d got %h %h %h %h %h %0d",
                            e.x, e.y, e.z, e.m, e.err, e.st, out_x, out_y, out_z,
                            out_inv_mass, constraint_error, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        fork
            begin
                wait (sender_done);
                wait (pending_res.size() == 0);
                repeat (DRAIN_WAIT) @(posedge clk);
            end
            begin
                wait (idle_cycles >= STALL_LIM);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatches == 0 && pending_res.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
